FILE: hw/rtl/jps_pkg.sv
// Shared types, widths and constants for the joint pose interpolation unit.
// No dependencies; every other file imports this package.
package jps_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int T_W           = 17;
  localparam int DOT_W         = 66;
  localparam int C_W           = 31;
  localparam int X_W           = 34;
  localparam int Z_W           = 36;
  localparam int K_W           = 34;
  localparam int R_W           = 32;
  localparam int DIV_W         = 64;
  localparam int CORDIC_STEPS  = 30;
  localparam int ISQ_STEPS     = 31;
  localparam int DIV_STEPS     = DIV_W;
  localparam int Q_DEPTH       = 8;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  localparam logic [T_W-1:0]        T_ONE       = T_W'(65536);
  localparam logic signed [X_W-1:0] CORDIC_GAIN = X_W'(652032874);
  localparam logic signed [K_W-1:0] K_ONE       = K_W'(64'h4000_0000);

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef enum logic [3:0] {
    CLS_LIN    = 4'b0001,
    CLS_PASS_A = 4'b0010,
    CLS_PASS_B = 4'b0100,
    CLS_SLERP  = 4'b1000
  } cls_t;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic              last_joint;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic              result_last;
  } rsp_t;

  typedef struct packed {
    logic             kind;
    logic             last;
    cls_t             cls;
    logic [3:0][31:0] a;
    logic [3:0][32:0] b;
    logic [C_W-1:0]   c;
  } qent_t;

endpackage

FILE: hw/rtl/jps_front.sv
// Front end: takes request words, forms the quaternion dot product and
// classifies each word. Depends on jps_pkg.
module jps_front import jps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           acc,
  input  req_t           item,
  input  logic [T_W-1:0] t,
  output logic           push,
  output qent_t          ent,
  output logic [1:0]     inflight
);

  localparam logic [DOT_W-1:0] NEAR_LIMIT = DOT_W'((64'd9999 << FRAC_BITS) / 10000);

  logic                    v1, v2, v3;
  req_t                    it1, it2;
  logic signed [63:0]      prod1 [4];
  logic signed [DOT_W-1:0] dot2;
  logic                    neg;
  logic [DOT_W-1:0]        mag;
  logic                    mid_t;
  logic [3:0][31:0]        a_v;
  logic [3:0][31:0]        b_v;
  qent_t                   ent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    it1      <= item;
    prod1[0] <= item.a_x * item.b_x;
    prod1[1] <= item.a_y * item.b_y;
    prod1[2] <= item.a_z * item.b_z;
    prod1[3] <= item.a_w * item.b_w;
    it2      <= it1;
    dot2     <= DOT_W'(prod1[0] >>> FRAC_BITS) + DOT_W'(prod1[1] >>> FRAC_BITS)
              + DOT_W'(prod1[2] >>> FRAC_BITS) + DOT_W'(prod1[3] >>> FRAC_BITS);
    ent      <= ent_next;
  end

  always_comb begin
    neg   = dot2[DOT_W-1];
    mag   = neg ? DOT_W'(-dot2) : DOT_W'(dot2);
    mid_t = (t != '0) && (t < T_ONE);
    a_v   = {it2.a_w, it2.a_z, it2.a_y, it2.a_x};
    b_v   = {it2.b_w, it2.b_z, it2.b_y, it2.b_x};
    ent_next.kind = it2.req_type;
    ent_next.last = it2.last_joint;
    ent_next.a    = a_v;
    ent_next.c    = C_W'(mag << (30 - FRAC_BITS));
    for (int i = 0; i < 4; i++) begin
      // flip B onto the short arc
      if (it2.req_type && mid_t && neg) begin
        ent_next.b[i] = -{b_v[i][31], b_v[i]};
      end else begin
        ent_next.b[i] = {b_v[i][31], b_v[i]};
      end
    end
    priority if (!it2.req_type) begin
      ent_next.cls = CLS_LIN;
    end else if (t == '0) begin
      ent_next.cls = CLS_PASS_A;
    end else if (t >= T_ONE) begin
      ent_next.cls = CLS_PASS_B;
    end else if (mag > NEAR_LIMIT) begin
      ent_next.cls = CLS_LIN;
    end else begin
      ent_next.cls = CLS_SLERP;
    end
  end

  assign push     = v3;
  assign inflight = 2'(v1) + 2'(v2) + 2'(v3);

endmodule

FILE: hw/rtl/jps_queue.sv
// Short queue between front and back end, registered read port.
// Depends on jps_pkg.
module jps_queue import jps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qent_t              wdata,
  output logic               rvalid,
  output qent_t              rdata,
  output logic [Q_CNT_W-1:0] count
);

  qent_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic               pop;

  assign pop = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count  <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
      rvalid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
    if (pop) rdata <= mem[rptr];
  end

endmodule

FILE: hw/rtl/jps_back.sv
// Back end: square root, CORDIC angle and sines, weight division and the
// final weighted blend, one word per cycle. Depends on jps_pkg.
module jps_back import jps_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_v,
  input  qent_t          in_e,
  input  logic [T_W-1:0] t,
  output logic           done,
  output rsp_t           result
);

  localparam int SIDE_LEN = 2 + ISQ_STEPS + 1 + CORDIC_STEPS + 2 + CORDIC_STEPS + 1 + DIV_STEPS;
  localparam int C_TAP    = 2 + ISQ_STEPS;
  localparam int P_W      = T_W + 1 + Z_W;

  // side line carries the word alongside the arithmetic
  qent_t side [0:SIDE_LEN];
  logic  vld  [0:SIDE_LEN];

  assign side[0] = in_e;
  assign vld[0]  = in_v;

  for (genvar k = 0; k < SIDE_LEN; k++) begin : g_side
    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
    end
  end

  // integer square root of 2^60 - c^2
  logic [61:0]    csq;
  logic [60:0]    isq_rem [0:ISQ_STEPS];
  logic [61:0]    isq_res [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    csq        <= 62'(side[0].c) * 62'(side[0].c);
    isq_rem[0] <= (61'(1) << 60) - csq[60:0];
    isq_res[0] <= '0;
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam logic [61:0] BITV = 62'(1) << (60 - 2 * j);
    logic [61:0] trial;
    assign trial = isq_res[j] + BITV;
    always_ff @(posedge clk) begin
      if ({1'b0, isq_rem[j]} >= trial) begin
        isq_rem[j+1] <= isq_rem[j] - trial[60:0];
        isq_res[j+1] <= (isq_res[j] >> 1) + BITV;
      end else begin
        isq_rem[j+1] <= isq_rem[j];
        isq_res[j+1] <= isq_res[j] >> 1;
      end
    end
  end

  // vectoring CORDIC: w = atan2(s, c)
  logic signed [X_W-1:0] at_x [0:CORDIC_STEPS];
  logic signed [X_W-1:0] at_y [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] at_z [0:CORDIC_STEPS];
  logic [C_W-1:0]        at_s [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    at_x[0] <= X_W'(side[C_TAP].c);
    at_y[0] <= X_W'(isq_res[ISQ_STEPS][C_W-1:0]);
    at_z[0] <= '0;
    at_s[0] <= isq_res[ISQ_STEPS][C_W-1:0];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
    always_ff @(posedge clk) begin
      at_s[i+1] <= at_s[i];
      if (at_y[i] > 0) begin
        at_x[i+1] <= at_x[i] + (at_y[i] >>> i);
        at_y[i+1] <= at_y[i] - (at_x[i] >>> i);
        at_z[i+1] <= at_z[i] + Z_W'(ATAN_TAB[i]);
      end else begin
        at_x[i+1] <= at_x[i] - (at_y[i] >>> i);
        at_y[i+1] <= at_y[i] + (at_x[i] >>> i);
        at_z[i+1] <= at_z[i] - Z_W'(ATAN_TAB[i]);
      end
    end
  end

  // scale the angle by 1 - t and t
  logic signed [T_W:0]   omt, tt;
  logic signed [P_W-1:0] p0, p1;
  logic [C_W-1:0]        ps;

  assign omt = $signed({1'b0, T_ONE}) - $signed({1'b0, t});
  assign tt  = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    p0 <= omt * at_z[CORDIC_STEPS];
    p1 <= tt * at_z[CORDIC_STEPS];
    ps <= at_s[CORDIC_STEPS];
  end

  // rotation CORDIC, two lanes: sin(u0), sin(u1)
  logic signed [X_W-1:0] sn_x [2][0:CORDIC_STEPS];
  logic signed [X_W-1:0] sn_y [2][0:CORDIC_STEPS];
  logic signed [Z_W-1:0] sn_z [2][0:CORDIC_STEPS];
  logic [C_W-1:0]        sn_s [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    sn_z[0][0] <= Z_W'((p0 + P_W'(32768)) >>> 16);
    sn_z[1][0] <= Z_W'((p1 + P_W'(32768)) >>> 16);
    sn_x[0][0] <= CORDIC_GAIN;
    sn_x[1][0] <= CORDIC_GAIN;
    sn_y[0][0] <= '0;
    sn_y[1][0] <= '0;
    sn_s[0]    <= ps;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin_s
    always_ff @(posedge clk) sn_s[i+1] <= sn_s[i];
  end

  for (genvar l = 0; l < 2; l++) begin : g_sin_lane
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin
      always_ff @(posedge clk) begin
        if (sn_z[l][i] >= 0) begin
          sn_x[l][i+1] <= sn_x[l][i] - (sn_y[l][i] >>> i);
          sn_y[l][i+1] <= sn_y[l][i] + (sn_x[l][i] >>> i);
          sn_z[l][i+1] <= sn_z[l][i] - Z_W'(ATAN_TAB[i]);
        end else begin
          sn_x[l][i+1] <= sn_x[l][i] + (sn_y[l][i] >>> i);
          sn_y[l][i+1] <= sn_y[l][i] - (sn_x[l][i] >>> i);
          sn_z[l][i+1] <= sn_z[l][i] + Z_W'(ATAN_TAB[i]);
        end
      end
    end
  end

  // restoring division: k = floor(sin * 2^30 / s), one quotient bit a stage
  logic [DIV_W-1:0] dv_d   [2][0:DIV_STEPS];
  logic [DIV_W-1:0] dv_q   [2][0:DIV_STEPS];
  logic [R_W-1:0]   dv_r   [2][0:DIV_STEPS];
  logic             dv_neg [2][0:DIV_STEPS];
  logic [C_W-1:0]   dv_s   [0:DIV_STEPS];

  always_ff @(posedge clk) dv_s[0] <= sn_s[CORDIC_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div_s
    always_ff @(posedge clk) dv_s[i+1] <= dv_s[i];
  end

  for (genvar l = 0; l < 2; l++) begin : g_div_lane
    logic signed [X_W-1:0] s_in;
    logic [X_W-1:0]        s_mag;
    assign s_in  = sn_y[l][CORDIC_STEPS];
    assign s_mag = s_in[X_W-1] ? X_W'(-s_in) : X_W'(s_in);

    always_ff @(posedge clk) begin
      dv_d[l][0]   <= {s_mag, 30'b0};
      dv_q[l][0]   <= '0;
      dv_r[l][0]   <= '0;
      dv_neg[l][0] <= s_in[X_W-1];
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [R_W-1:0] rr;
      assign rr = {dv_r[l][i][R_W-2:0], dv_d[l][i][DIV_W-1]};
      always_ff @(posedge clk) begin
        dv_d[l][i+1]   <= dv_d[l][i] << 1;
        dv_neg[l][i+1] <= dv_neg[l][i];
        if (rr >= R_W'(dv_s[i])) begin
          dv_r[l][i+1] <= rr - R_W'(dv_s[i]);
          dv_q[l][i+1] <= {dv_q[l][i][DIV_W-2:0], 1'b1};
        end else begin
          dv_r[l][i+1] <= rr;
          dv_q[l][i+1] <= {dv_q[l][i][DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  // pick the weights per class
  logic signed [K_W-1:0] kdiv [2];
  logic signed [K_W-1:0] k0_next, k1_next, k_lin;
  logic signed [K_W-1:0] k0r, k1r;
  qent_t                 fx, mx;
  logic                  kv, mv;

  for (genvar l = 0; l < 2; l++) begin : g_kfix
    logic signed [K_W-1:0] kq;
    assign kq = K_W'(dv_q[l][DIV_STEPS]);
    // floor towards minus infinity for a negative sine
    assign kdiv[l] = dv_neg[l][DIV_STEPS]
                   ? -kq - K_W'(dv_r[l][DIV_STEPS] != '0) : kq;
  end

  assign k_lin = K_W'({t, 14'b0});

  always_comb begin
    unique case (side[SIDE_LEN].cls)
      CLS_LIN: begin
        k1_next = k_lin;
        k0_next = K_ONE - k_lin;
      end
      CLS_PASS_A: begin
        k0_next = K_ONE;
        k1_next = '0;
      end
      CLS_PASS_B: begin
        k0_next = '0;
        k1_next = K_ONE;
      end
      CLS_SLERP: begin
        if (dv_s[DIV_STEPS] == '0) begin
          k0_next = K_ONE;
          k1_next = '0;
        end else begin
          k0_next = kdiv[0];
          k1_next = kdiv[1];
        end
      end
      default: begin
        k0_next = K_ONE;
        k1_next = '0;
      end
    endcase
  end

  logic signed [66:0] m0 [4];
  logic signed [66:0] m1 [4];
  logic signed [67:0] blend [4];
  logic signed [37:0] sh [4];
  logic [31:0]        comp [4];

  always_ff @(posedge clk) begin
    k0r <= k0_next;
    k1r <= k1_next;
    fx  <= side[SIDE_LEN];
    mx  <= fx;
    for (int i = 0; i < 4; i++) begin
      m0[i] <= k0r * $signed(fx.a[i]);
      m1[i] <= k1r * $signed(fx.b[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      blend[i] = 68'(m0[i]) + 68'(m1[i]) + 68'sd536870912;
      sh[i]    = 38'(blend[i] >>> 30);
      if (sh[i] > 38'sd2147483647) begin
        comp[i] = 32'h7fff_ffff;
      end else if (sh[i] < -38'sd2147483648) begin
        comp[i] = 32'h8000_0000;
      end else begin
        comp[i] = sh[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kv   <= 1'b0;
      mv   <= 1'b0;
      done <= 1'b0;
    end else begin
      kv   <= vld[SIDE_LEN];
      mv   <= kv;
      done <= mv;
    end
  end

  always_ff @(posedge clk) begin
    result.result_kind <= mx.kind;
    result.result_last <= mx.last;
    result.r_x         <= comp[0];
    result.r_y         <= comp[1];
    result.r_z         <= comp[2];
    result.r_w         <= mx.kind ? comp[3] : 32'h0;
  end

endmodule

FILE: hw/rtl/joint_pose_slerp_lerp.sv
// Top level: configuration register, front end, queue and back end.
// Depends on jps_pkg, jps_front, jps_queue, jps_back.
//
//   channel   ports                      handshake
//   request   start, busy, item          taken when start & !busy
//   result    done, result               one cycle per word, no back-pressure
//   config    cfg_we, cfg_wdata          written when cfg_we
//
// One word per cycle in steady state; the delay from taking a word to its result
// is set by the square-root, CORDIC and divide stages.
// rst is synchronous and clears all valid bits and the fraction register.
// busy rises only when the queue and the front stages together are full.
module joint_pose_slerp_lerp import jps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  req_t           item,
  input  logic           cfg_we,
  input  logic [T_W-1:0] cfg_wdata,
  output logic           done,
  output rsp_t           result
);

  logic [T_W-1:0]     interp_fraction;
  logic               acc;
  logic               push;
  qent_t              fent;
  logic [1:0]         inflight;
  logic               qv;
  qent_t              qent;
  logic [Q_CNT_W-1:0] qcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_fraction <= '0;
    end else if (cfg_we) begin
      interp_fraction <= cfg_wdata;
    end
  end

  assign busy = ((Q_CNT_W + 1)'(qcount) + (Q_CNT_W + 1)'(inflight)) >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign acc  = start && !busy;

  jps_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .item     (item),
    .t        (interp_fraction),
    .push     (push),
    .ent      (fent),
    .inflight (inflight)
  );

  jps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (fent),
    .rvalid (qv),
    .rdata  (qent),
    .count  (qcount)
  );

  jps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .in_v   (qv),
    .in_e   (qent),
    .t      (interp_fraction),
    .done   (done),
    .result (result)
  );

endmodule

FILE: bench/joint_pose_slerp_lerp_chk.sv
// Checker for the joint pose interpolation unit: watches the request, result and
// fraction register ports, predicts each result word and compares. Needs jps_pkg.
module joint_pose_slerp_lerp_chk import jps_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  req_t           item,
  input  logic           cfg_we,
  input  logic [T_W-1:0] cfg_wdata,
  input  logic           done,
  input  rsp_t           result,
  output int             fails,
  output int             pending
);

  localparam longint NEAR_DOT = (longint'(9999) << 16) / 10000;
  localparam longint ONE_Q30  = longint'(1) << 30;

  rsp_t           pose_fifo[$];
  logic [T_W-1:0] fraction;

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(longint z);
    longint x, y, dx, dy;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    return y;
  endfunction

  // floor(sn * 2^30 / s)
  function automatic longint weight_of(longint sn, longint s);
    longint q;
    if (sn >= 0) return (sn << 30) / s;
    q = -(((-sn) << 30) / s);
    if ((((-sn) << 30) % s) != 0) q -= 1;
    return q;
  endfunction

  function automatic rsp_t blend_pose(req_t rq, logic [T_W-1:0] frac);
    rsp_t   r;
    longint a[4], b[4], o[4];
    longint t, dot, k0, k1, c, s, w;
    t = longint'(frac);
    a = '{longint'(rq.a_x), longint'(rq.a_y), longint'(rq.a_z), longint'(rq.a_w)};
    b = '{longint'(rq.b_x), longint'(rq.b_y), longint'(rq.b_z), longint'(rq.b_w)};
    r.result_kind = rq.req_type;
    r.result_last = rq.last_joint;
    if (!rq.req_type) begin
      for (int i = 0; i < 3; i++) o[i] = a[i] + round_shr(t * (b[i] - a[i]), 16);
      r.r_x = clamp32(o[0]); r.r_y = clamp32(o[1]); r.r_z = clamp32(o[2]);
      r.r_w = '0;
      return r;
    end
    if (t == 0) begin
      o = a;
    end else if (t >= 65536) begin
      o = b;
    end else begin
      dot = 0;
      for (int i = 0; i < 4; i++) dot += (a[i] * b[i]) >>> 16;
      if (dot < 0) begin
        for (int i = 0; i < 4; i++) b[i] = -b[i];
        dot = -dot;
      end
      if (dot > NEAR_DOT) begin
        k1 = t << 14;
        k0 = ONE_Q30 - k1;
      end else begin
        c = dot << 14;
        s = int_sqrt((64'd1 << 60) - longint'(c * c));
        if (s <= 0) begin
          k0 = ONE_Q30;
          k1 = 0;
        end else begin
          w  = angle_of(s, c);
          k0 = weight_of(sine_of(round_shr((65536 - t) * w, 16)), s);
          k1 = weight_of(sine_of(round_shr(t * w, 16)), s);
        end
      end
      for (int i = 0; i < 4; i++) o[i] = round_shr(k0 * a[i] + k1 * b[i], 30);
    end
    r.r_x = clamp32(o[0]); r.r_y = clamp32(o[1]);
    r.r_z = clamp32(o[2]); r.r_w = clamp32(o[3]);
    return r;
  endfunction

  assign pending = pose_fifo.size();

  always @(posedge clk) begin
    rsp_t exp_w;
    if (rst) begin
      fraction <= '0;
      fails    <= 0;
      pose_fifo.delete();
    end else begin
      if (start && !busy) pose_fifo.push_back(blend_pose(item, fraction));
      if (cfg_we) fraction <= cfg_wdata;
      if (done) begin
        if (pose_fifo.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, result);
          fails <= fails + 1;
        end else begin
          exp_w = pose_fifo.pop_front();
          if (exp_w.result_kind !== result.result_kind || exp_w.r_x !== result.r_x ||
              exp_w.r_y !== result.r_y || exp_w.r_z !== result.r_z ||
              exp_w.r_w !== result.r_w || exp_w.result_last !== result.result_last) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, result);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/joint_pose_slerp_lerp_tb.sv
// Testbench top for joint_pose_slerp_lerp: clock, reset, stimulus and verdict.
// Depends on jps_pkg, the block and joint_pose_slerp_lerp_chk.
module joint_pose_slerp_lerp_tb;
  import jps_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic           clk, rst, start, busy, cfg_we, done;
  logic [T_W-1:0] cfg_wdata;
  req_t           item;
  rsp_t           result;
  int             fails, pending, idle_cycles;

  joint_pose_slerp_lerp dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  joint_pose_slerp_lerp_chk chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] unit_comp();
    return 32'($urandom_range(0, 131072)) - 32'd65536;
  endfunction

  function automatic logic [31:0] any_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return unit_comp();
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Present one word and hold it until taken; busy is stable at the falling edge.
  task automatic send_word(req_t w);
    item  = w;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    idle_gap();
  endtask

  task automatic write_fraction(logic [T_W-1:0] v);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_random(int n);
    req_t w;
    logic [31:0] d;
    for (int k = 0; k < n; k++) begin
      w.req_type   = $urandom_range(0, 3) != 0;
      w.last_joint = $urandom_range(0, 7) == 0;
      w.a_x = any_comp(); w.a_y = any_comp(); w.a_z = any_comp(); w.a_w = any_comp();
      case ($urandom_range(0, 5))
        0, 1: begin
          // same or opposite orientation with small jitter: near-threshold path
          d = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'd1;
          w.b_x = w.a_x * d + 32'($urandom_range(0, 40)) - 32'd20;
          w.b_y = w.a_y * d + 32'($urandom_range(0, 40)) - 32'd20;
          w.b_z = w.a_z * d + 32'($urandom_range(0, 40)) - 32'd20;
          w.b_w = w.a_w * d + 32'($urandom_range(0, 40)) - 32'd20;
        end
        default: begin
          w.b_x = any_comp(); w.b_y = any_comp(); w.b_z = any_comp(); w.b_w = any_comp();
        end
      endcase
      send_word(w);
    end
  endtask

  task automatic send_directed();
    req_t w;
    w = '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0,
          32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'hFFFF_FFFF, 1'b1};
    send_word(w);
    w = '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 1'b0};
    send_word(w);
    // identical unit quaternions, then exactly opposite ones
    w = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 1'b0};
    send_word(w);
    w = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0,
          32'hFFFF_0000, 1'b1};
    send_word(w);
    // right angle, negative dot, then either side of the threshold
    w = '{1'b1, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 1'b0};
    send_word(w);
    w = '{1'b1, 32'd46341, 32'd0, 32'd0, 32'd46341, 32'hFFFF_4B3F, 32'd0,
          32'd0, 32'hFFFF_4B3F, 1'b0};
    send_word(w);
    w = '{1'b1, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65529, 32'd0, 32'd0, 32'd0, 1'b0};
    send_word(w);
    w = '{1'b1, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65530, 32'd0, 32'd0, 32'd0, 1'b0};
    send_word(w);
    // not unit length: large dot, zero vectors, full-scale values
    w = '{1'b1, 32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'h0010_0000, 32'd0, 32'd0,
          32'd0, 1'b0};
    send_word(w);
    w = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    send_word(w);
    w = '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
    send_word(w);
  endtask

  initial begin
    logic [T_W-1:0] fracs[8];
    fracs = '{17'd0, 17'd65536, 17'd1, 17'd65535, 17'd32768, 17'd131071,
              17'd65537, 17'd16384};
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; item = '0;
    idle_cycles = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    send_directed();
    for (int p = 0; p < 8; p++) begin
      write_fraction(fracs[p]);
      send_directed();
      send_random(99);
    end
    for (int p = 0; p < 3; p++) begin
      write_fraction(17'($urandom_range(0, 131071)));
      send_random(20);
    end
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/jps_pkg.sv
hw/rtl/jps_front.sv
hw/rtl/jps_queue.sv
hw/rtl/jps_back.sv
hw/rtl/joint_pose_slerp_lerp.sv
bench/joint_pose_slerp_lerp_chk.sv
bench/joint_pose_slerp_lerp_tb.sv
